// ===== hw/rtl/bhlc_pkg.sv =====
// shared types and constants for the bmp / ppm header length checker
package bhlc_pkg;

  typedef enum logic [3:0] {
    PH_START,
    PH_BMP_M,
    PH_BMP_SIZE,
    PH_PPM_6,
    PH_PPM_SP,
    PH_SKIP0,
    PH_SKIP1,
    PH_SKIP2,
    PH_NUM0,
    PH_NUM1,
    PH_NUM2,
    PH_CRLF,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    DEC_PEND,
    DEC_REJ,
    DEC_ACC
  } dec_t;

  localparam logic [1:0] FMT_NONE = 2'd0;
  localparam logic [1:0] FMT_BMP  = 2'd1;
  localparam logic [1:0] FMT_PPM  = 2'd2;

  localparam logic [31:0] CAP_RESET = 32'd65536;
  localparam logic [31:0] CAP_MIN   = 32'd64;
  localparam logic [31:0] BMP_MIN   = 32'd54;
  localparam logic [31:0] MAXVAL    = 32'd255;
  localparam logic [31:0] BMP_LAST_POS = 32'd5;

  localparam logic [7:0] CH_B   = 8'h42;
  localparam logic [7:0] CH_M   = 8'h4D;
  localparam logic [7:0] CH_P   = 8'h50;
  localparam logic [7:0] CH_6   = 8'h36;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

endpackage

// ===== hw/rtl/bhlc_stream_if.sv =====
// valid/ready channel interfaces for input bytes and verdicts
interface bhlc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last;

  modport source(output valid, byte_value, last, input ready);
  modport sink(input valid, byte_value, last, output ready);
endinterface

interface bhlc_verdict_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [1:0]  image_format;
  logic [31:0] total_length;

  modport source(output valid, accepted, image_format, total_length, input ready);
  modport sink(input valid, accepted, image_format, total_length, output ready);
endinterface

// ===== hw/rtl/bhlc_length_unit.sv =====
// registered width * height * 3 for the ppm pixel byte count
module bhlc_length_unit #(
  parameter int AW = 14
) (
  input  logic              clk,
  input  logic [AW-1:0]     image_width,
  input  logic [AW-1:0]     image_height,
  output logic [2*AW+1:0]   pixel_bytes
);

  logic [2*AW-1:0] prod;

  // two register stages; height is known several bytes before maxval ends
  always_ff @(posedge clk) begin
    prod        <= image_width * image_height;
    pixel_bytes <= (2*AW+2)'(prod) + {1'b0, prod, 1'b0};
  end

endmodule

// ===== hw/rtl/bmp_ppm_header_length_check.sv =====
// top level: bmp / binary ppm header parser with length check against buffer capacity
// a verdict is registered: the deciding byte passes the input register, then sets the verdict register
// throughput: one byte per cycle; ready drops only while the verdict register is held
//   by the sink and the input register is full
// reset: synchronous, clears the parser to start of stream and capacity to 65536
// the ppm length product is taken from a two-stage registered multiplier
module bmp_ppm_header_length_check #(
  parameter int NUMBER_LIMIT = 8192
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  bhlc_byte_if.sink            byte_in,
  bhlc_verdict_if.source       verdict_out
);
  import bhlc_pkg::*;

  localparam int AW = $clog2(NUMBER_LIMIT + 1);
  localparam int SW = AW + 4;
  localparam int PW = 2 * AW + 2;
  localparam int TW = ((PW > 33) ? PW : 33) + 1;

  // input register
  logic        s_valid;
  logic [7:0]  s_byte;
  logic        s_last;

  // parser state
  phase_t          phase, phase_next;
  logic [31:0]     byte_position;
  logic [AW-1:0]   acc, acc_next;
  logic [AW-1:0]   image_width, image_width_next;
  logic [AW-1:0]   image_height, image_height_next;
  logic [31:0]     bmp_size_word, bmp_size_word_next;
  logic [31:0]     cap;

  // verdict register
  logic        o_valid;
  logic        o_accepted;
  logic [1:0]  o_format;
  logic [31:0] o_length;

  logic            advance;
  dec_t            dec;
  logic [1:0]      fmt;
  logic [31:0]     bmp_len;
  logic [3:0]      digit;
  logic [SW-1:0]   acc_sum;
  logic            hdr_inc;
  logic [32:0]     hdr;
  logic [TW-1:0]   total;
  logic            fits;
  logic [PW-1:0]   pixel_bytes;

  bhlc_length_unit #(.AW(AW)) u_len (
    .clk          (clk),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel_bytes  (pixel_bytes)
  );

  assign advance       = s_valid && (!o_valid || verdict_out.ready);
  assign byte_in.ready = !s_valid || advance;

  assign verdict_out.valid        = o_valid;
  assign verdict_out.accepted     = o_accepted;
  assign verdict_out.image_format = o_format;
  assign verdict_out.total_length = o_length;

  // ascii digits carry their value in the low nibble
  assign digit   = s_byte[3:0];
  assign acc_sum = SW'({acc, 3'b000}) + SW'({acc, 1'b0}) + SW'(digit);

  // header ends one past the current byte, except after a cr, where the byte counts only if it is lf below capacity
  always_comb begin
    if (phase == PH_CRLF) begin
      hdr_inc = (byte_position < cap) && (s_byte == CH_LF);
    end else begin
      hdr_inc = 1'b1;
    end
  end

  assign hdr   = {1'b0, byte_position} + 33'(hdr_inc);
  assign total = TW'(hdr) + TW'(pixel_bytes);
  assign fits  = total < TW'(cap);

  always_comb begin
    phase_next         = phase;
    acc_next           = acc;
    image_width_next   = image_width;
    image_height_next  = image_height;
    bmp_size_word_next = bmp_size_word;
    dec                = DEC_PEND;
    fmt                = FMT_NONE;
    bmp_len            = bmp_size_word_next;
    if (phase != PH_DONE) begin
      if (phase != PH_CRLF && byte_position >= cap) begin
        dec = DEC_REJ;
      end else begin
        unique case (phase)
          PH_START: begin
            if (cap < CAP_MIN) dec = DEC_REJ;
            else if (s_byte == CH_B) phase_next = PH_BMP_M;
            else if (s_byte == CH_P) phase_next = PH_PPM_6;
            else dec = DEC_REJ;
          end
          PH_BMP_M: begin
            if (s_byte == CH_M) phase_next = PH_BMP_SIZE;
            else dec = DEC_REJ;
          end
          PH_BMP_SIZE: begin
            bmp_size_word_next = {s_byte, bmp_size_word[31:8]};
            bmp_len = bmp_size_word_next;
            if (byte_position >= BMP_LAST_POS) begin
              if (bmp_size_word_next >= BMP_MIN && bmp_size_word_next < cap) begin
                dec = DEC_ACC;
                fmt = FMT_BMP;
              end else begin
                dec = DEC_REJ;
              end
            end
          end
          PH_PPM_6: begin
            if (s_byte == CH_6) phase_next = PH_PPM_SP;
            else dec = DEC_REJ;
          end
          PH_PPM_SP: begin
            if (is_ws(s_byte)) phase_next = PH_SKIP0;
            else dec = DEC_REJ;
          end
          PH_SKIP0, PH_SKIP1, PH_SKIP2: begin
            if (!is_ws(s_byte)) begin
              if (!is_dig(s_byte)) begin
                dec = DEC_REJ;
              end else if (SW'(digit) > SW'(NUMBER_LIMIT)) begin
                dec = DEC_REJ;
              end else begin
                acc_next = AW'(digit);
                priority case (phase)
                  PH_SKIP0: phase_next = PH_NUM0;
                  PH_SKIP1: phase_next = PH_NUM1;
                  default:  phase_next = PH_NUM2;
                endcase
              end
            end
          end
          PH_NUM0, PH_NUM1, PH_NUM2: begin
            if (is_dig(s_byte)) begin
              acc_next = AW'(acc_sum);
              if (acc_sum > SW'(NUMBER_LIMIT)) dec = DEC_REJ;
            end else if (!is_ws(s_byte)) begin
              dec = DEC_REJ;
            end else if (phase == PH_NUM0) begin
              image_width_next = acc;
              phase_next = PH_SKIP1;
            end else if (phase == PH_NUM1) begin
              image_height_next = acc;
              phase_next = PH_SKIP2;
            end else if (32'(acc) != MAXVAL) begin
              dec = DEC_REJ;
            end else if (s_byte == CH_CR) begin
              phase_next = PH_CRLF;
            end else begin
              dec = fits ? DEC_ACC : DEC_REJ;
              fmt = FMT_PPM;
            end
          end
          PH_CRLF: begin
            dec = fits ? DEC_ACC : DEC_REJ;
            fmt = FMT_PPM;
          end
          default: dec = DEC_REJ;
        endcase
      end
      // stream ended with the decision still open
      if (dec == DEC_PEND && s_last) dec = DEC_REJ;
      if (dec != DEC_PEND) phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      s_byte <= byte_in.byte_value;
      s_last <= byte_in.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      byte_position <= 32'd0;
    end else if (advance) begin
      if (s_last) begin
        phase         <= PH_START;
        byte_position <= 32'd0;
      end else begin
        phase <= phase_next;
        if (byte_position != 32'hFFFF_FFFF) byte_position <= byte_position + 32'd1;
      end
    end
  end

  // payload state, always rewritten before use within a stream
  always_ff @(posedge clk) begin
    if (advance) begin
      acc           <= acc_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      bmp_size_word <= bmp_size_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance && dec != DEC_PEND) begin
      o_valid <= 1'b1;
    end else if (verdict_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec != DEC_PEND) begin
      o_accepted <= (dec == DEC_ACC);
      o_format   <= (dec == DEC_ACC) ? fmt : FMT_NONE;
      if (dec != DEC_ACC) o_length <= 32'd0;
      else if (fmt == FMT_BMP) o_length <= bmp_len;
      else o_length <= total[31:0];
    end
  end

endmodule

// ===== hw/rtl/bhlc_checker.sv =====
// port-level assertions for the header length checker, bound to the top level
module bhlc_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [31:0] cfg_wdata,
  input logic        out_valid,
  input logic        out_ready,
  input logic        accepted,
  input logic [1:0]  image_format,
  input logic [31:0] total_length
);
  import bhlc_pkg::*;

  logic [31:0] cap_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_shadow <= CAP_RESET;
    end else if (cfg_we) begin
      cap_shadow <= cfg_wdata;
    end
  end

  // a held verdict word does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({accepted, image_format, total_length}))
    else $error("verdict changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("verdict valid after reset");

  // an accepted length always fits the buffer
  a_fits: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> total_length < cap_shadow &&
      (image_format == FMT_BMP || image_format == FMT_PPM))
    else $error("accepted length does not fit capacity");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> image_format == FMT_NONE && total_length == 32'd0)
    else $error("rejection carries a payload");

endmodule

bind bmp_ppm_header_length_check bhlc_checker u_bhlc_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_we       (cfg_we),
  .cfg_wdata    (cfg_wdata),
  .out_valid    (verdict_out.valid),
  .out_ready    (verdict_out.ready),
  .accepted     (verdict_out.accepted),
  .image_format (verdict_out.image_format),
  .total_length (verdict_out.total_length)
);
